### rtl/rltd_pkg.sv
// Shared types, constants and helper functions of the run-length text decoder.
`default_nettype none

package rltd_pkg;

    localparam int DEF_QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [1:0] WANT_BYTE = 2'd0;
    localparam logic [1:0] WANT_TICK = 2'd1;
    localparam logic [1:0] WANT_DONE = 2'd2;

    localparam logic [1:0] CHAN_RED  = 2'd0;
    localparam logic [1:0] CHAN_BLUE = 2'd2;

    typedef enum logic [3:0] {
        PH_COUNT  = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_PIXEL  = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        K_CHAR,
        K_VALUE,
        K_WRONG
    } t_kind;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_burst;
        logic [1:0] next_wanted;
        logic       wrong_kind;
    } t_out_word;

    // one queued burst: what the back end has to spell out
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_val;
        logic [1:0] next_wanted;
    } t_desc;

    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      len;
        logic            wrong;
    } t_burst;

    function automatic logic [1:0] f_next_chan(input logic [1:0] c);
        f_next_chan = (c == CHAN_BLUE) ? CHAN_RED : c + 2'd1;
    endfunction

    function automatic logic [1:0] f_wanted(input t_phase ph, input logic done,
                                            input logic await_v, input logic run_zero);
        logic [1:0] w;
        unique case (ph)
            PH_COUNT, PH_HEADER: w = WANT_BYTE;
            PH_DONE:             w = WANT_DONE;
            default: begin
                if (done)
                    w = WANT_TICK;
                else if (await_v || run_zero)
                    w = WANT_BYTE;
                else
                    w = WANT_TICK;
            end
        endcase
        return w;
    endfunction

    function automatic t_burst f_expand(input t_desc d);
        t_burst     b;
        logic [1:0] h;
        logic [7:0] r;
        logic [3:0] t;
        logic [7:0] o;
        b       = '0;
        h       = (d.byte_val >= 8'd200) ? 2'd2 : (d.byte_val >= 8'd100) ? 2'd1 : 2'd0;
        r       = d.byte_val - ((h == 2'd2) ? 8'd200 : (h == 2'd1) ? 8'd100 : 8'd0);
        t       = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (r >= 8'(k * 10))
                t = 4'(k);
        end
        o       = r - {4'd0, t} * 8'd10;
        unique case (d.kind)
            K_CHAR: begin
                b.chars[0] = d.byte_val;
                b.len      = 3'd1;
            end
            K_VALUE: begin
                if (d.byte_val >= 8'd100) begin
                    b.chars = {CHAR_NEWLINE, CHAR_ZERO + o, CHAR_ZERO + {4'd0, t},
                               CHAR_ZERO + {6'd0, h}};
                    b.len   = 3'd4;
                end else if (d.byte_val >= 8'd10) begin
                    b.chars = {8'h00, CHAR_NEWLINE, CHAR_ZERO + o, CHAR_ZERO + {4'd0, t}};
                    b.len   = 3'd3;
                end else begin
                    b.chars = {16'h0000, CHAR_NEWLINE, CHAR_ZERO + o};
                    b.len   = 3'd2;
                end
            end
            default: begin
                b.len   = 3'd1;
                b.wrong = 1'b1;
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/rgb_run_length_text_decoder.sv
// Top level of the run-length image decoder that prints decimal text.
//
//  channel | direction | handshake                      | word
//  --------+-----------+--------------------------------+------------
//  in      | input     | i_in_valid / o_in_ready        | t_in_word
//  out     | output    | o_out_valid / i_out_ready      | t_out_word
//
// An item is taken while the queue has room; its burst of 1 to 4 words leaves at one word
// per cycle from the back end while i_out_ready is high.
// Silent items (count bytes and run bytes) produce no word.
// Synchronous active-low reset clears state and the queue; no clearing pass.
// The queue of QUEUE_DEPTH bursts lets input run ahead while output stalls.
`default_nettype none

module rgb_run_length_text_decoder import rltd_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_word  o_out_word
);

    logic  q_push, q_pop, q_full, q_empty;
    t_desc q_in, q_out;

    rltd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_desc   (q_in)
    );

    rltd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_desc  (q_out)
    );

    rltd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_desc    (q_out),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### rtl/rltd_front.sv
// Front end: accepts items, checks their kind, updates decoder state, queues bursts.
`default_nettype none

module rltd_front import rltd_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    input  wire        i_q_full,
    output logic       o_q_push,
    output t_desc      o_q_desc
);

    t_phase          r_phase,    n_phase;
    logic [7:0]      r_hdr_left, n_hdr_left;
    logic [1:0]      r_chan,     n_chan;
    logic            r_await,    n_await;
    logic [2:0][8:0] r_run,      n_run;
    logic [2:0][7:0] r_sample,   n_sample;
    logic            r_done,     n_done;

    logic       hit, good, visit, echo, settle;
    logic [1:0] exp_kind;
    logic [7:0] value;
    logic [1:0] c1, c2;

    assign o_in_ready = !i_q_full;
    assign hit        = i_in_valid && o_in_ready;
    assign exp_kind   = f_wanted(r_phase, r_done, r_await, r_run[r_chan] == 9'd0);
    assign good       = (exp_kind != WANT_DONE) && ({1'b0, i_in_word.mode} == exp_kind);

    always_comb begin
        n_phase    = r_phase;
        n_hdr_left = r_hdr_left;
        n_chan     = r_chan;
        n_await    = r_await;
        n_run      = r_run;
        n_sample   = r_sample;
        n_done     = r_done;
        visit      = 1'b0;
        echo       = 1'b0;
        settle     = 1'b0;
        value      = r_sample[r_chan];
        c1         = 2'd0;
        c2         = 2'd0;
        if (i_in_word.mode) begin
            visit  = 1'b1;
            settle = r_done;
        end else begin
            unique case (r_phase)
                PH_COUNT: begin
                    n_hdr_left = i_in_word.data_byte;
                    n_phase    = (i_in_word.data_byte != 8'd0) ? PH_HEADER : PH_PIXEL;
                end
                PH_HEADER: begin
                    echo = 1'b1;
                    if (i_in_word.data_byte == CHAR_NEWLINE) begin
                        n_hdr_left = r_hdr_left - 8'd1;
                        if (r_hdr_left == 8'd1)
                            n_phase = PH_PIXEL;
                    end
                end
                PH_PIXEL: begin
                    if (r_await) begin
                        n_sample[r_chan] = i_in_word.data_byte;
                        value            = i_in_word.data_byte;
                        n_await          = 1'b0;
                        visit            = 1'b1;
                    end else begin
                        n_run[r_chan] = {1'b0, i_in_word.data_byte} + 9'd1;
                        n_await       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        if (visit) begin
            if (n_run[r_chan] != 9'd0)
                n_run[r_chan] = n_run[r_chan] - 9'd1;
            n_chan = f_next_chan(r_chan);
        end
        if (!i_in_word.mode && i_in_word.final_byte) begin
            n_done = 1'b1;
            if (n_phase == PH_COUNT || n_phase == PH_HEADER) begin
                n_phase = PH_DONE;
            end else begin
                if (n_await) begin
                    n_run[n_chan] = 9'd0;
                    n_await       = 1'b0;
                end
                settle = 1'b1;
            end
        end
        if (settle) begin
            c1 = f_next_chan(n_chan);
            c2 = f_next_chan(c1);
            if (n_run[n_chan] != 9'd0)
                n_chan = n_chan;
            else if (n_run[c1] != 9'd0)
                n_chan = c1;
            else if (n_run[c2] != 9'd0)
                n_chan = c2;
            else
                n_phase = PH_DONE;
        end
    end

    always_comb begin
        o_q_push            = hit && (!good || echo || visit);
        o_q_desc.kind       = !good ? K_WRONG : (echo ? K_CHAR : K_VALUE);
        o_q_desc.byte_val   = echo ? i_in_word.data_byte : value;
        o_q_desc.next_wanted = !good ? exp_kind
                             : f_wanted(n_phase, n_done, n_await, n_run[n_chan] == 9'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_COUNT;
            r_hdr_left <= '0;
            r_chan     <= CHAN_RED;
            r_await    <= 1'b0;
            r_run      <= '0;
            r_done     <= 1'b0;
        end else if (hit && good) begin
            r_phase    <= n_phase;
            r_hdr_left <= n_hdr_left;
            r_chan     <= n_chan;
            r_await    <= n_await;
            r_run      <= n_run;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit && good)
            r_sample <= n_sample;
    end

endmodule

`default_nettype wire

### rtl/rltd_queue.sv
// Short queue of burst descriptors between front end and back end.
`default_nettype none

module rltd_queue import rltd_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  wire   i_pop,
    output logic  o_empty,
    output t_desc o_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_desc;
    end

endmodule

`default_nettype wire

### rtl/rltd_back.sv
// Back end: spells queued bursts out as characters, one word per cycle while i_out_ready is high.
`default_nettype none

module rltd_back import rltd_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_empty,
    input  t_desc      i_q_desc,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_word  o_out_word
);

    logic [3:0][7:0] r_buf;
    logic [2:0]      r_left;
    logic [1:0]      r_nw;
    logic            r_wrong;
    t_burst          burst;
    logic            take;

    assign burst       = f_expand(i_q_desc);
    assign o_out_valid = (r_left != 3'd0);
    assign take        = o_out_valid && i_out_ready;
    assign o_q_pop     = !i_q_empty && (!o_out_valid || (take && r_left == 3'd1));

    assign o_out_word.out_char     = r_buf[0];
    assign o_out_word.end_of_burst = (r_left == 3'd1);
    assign o_out_word.next_wanted  = r_nw;
    assign o_out_word.wrong_kind   = r_wrong;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (o_q_pop) begin
            r_left <= burst.len;
        end else if (take) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_buf   <= burst.chars;
            r_nw    <= i_q_desc.next_wanted;
            r_wrong <= burst.wrong;
        end else if (take) begin
            r_buf   <= {8'h00, r_buf[3:1]};
        end
    end

endmodule

`default_nettype wire

### rtl/rltd_checker.sv
// Port-level checker of the decoder and its bind to the top level.
`default_nettype none

module rltd_checker import rltd_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_ready,
    input t_in_word  i_in_word,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input t_out_word o_out_word
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_word))
        else $error("input word dropped or changed while waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word dropped or changed while stalled");

    a_wrong_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.wrong_kind |->
            o_out_word.end_of_burst && o_out_word.out_char == 8'h00)
        else $error("wrong-kind word is not a lone empty word");

    a_finished_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.next_wanted == WANT_DONE
            |=> !o_out_valid || o_out_word.next_wanted == WANT_DONE)
        else $error("decoder left the finished state");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind rgb_run_length_text_decoder rltd_checker u_rltd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire
